// File: rtl/fqrr_pkg.sv
// Package for the four-queue round-robin merge unit.
// Holds payload widths, the operation codes and the result status codes; no dependencies.
package fqrr_pkg;

  localparam int unsigned IdW  = 40;
  localparam int unsigned SelW = 2;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_FULL  = 2'd1,
    ST_POP   = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    FN_ENQ = 1'b0,
    FN_POP = 1'b1
  } func_e;

endpackage

// File: rtl/fqrr_in_if.sv
// Input channel of the merge unit: operation, queue select and identifier.
// Depends on fqrr_pkg for the payload widths.
interface fqrr_in_if;
  import fqrr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [SelW-1:0]        queue_sel;
  logic [IdW-1:0]         flight_id;

  modport source (output valid, func, queue_sel, flight_id, input ready);
  modport sink   (input valid, func, queue_sel, flight_id, output ready);
endinterface

// File: rtl/fqrr_out_if.sv
// Result channel of the merge unit: status, popped identifier, queue, last flag.
// Depends on fqrr_pkg for the payload widths.
interface fqrr_out_if;
  import fqrr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [IdW-1:0]         out_id;
  logic [SelW-1:0]        out_queue;
  logic                   last;

  modport source (output valid, status, out_id, out_queue, last, input ready);
  modport sink   (input valid, status, out_id, out_queue, last, output ready);
endinterface

// File: rtl/four_queue_round_robin_merge_unit.sv
// Four-queue round-robin merge unit: top level.
// Depends on fqrr_pkg, fqrr_in_if and fqrr_out_if.
//
// Takes one item per cycle and returns one result per item in the cycle after
// the transfer, through the registered read port of the ring memory that
// holds all queues (NUM_QUEUES x QUEUE_DEPTH identifiers). Head pointers,
// entry counts and the round-robin start live in flip-flops, so the search
// and the pointer update finish in the transfer cycle and the next item may
// follow at once; input ready drops only while a result is held and the
// sink is not ready. The ring memory is not cleared after reset: an entry is
// read only after it was written, and the unit is ready right out of reset.
module four_queue_round_robin_merge_unit #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned NUM_QUEUES  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fqrr_in_if.sink     in_i,
  fqrr_out_if.source  out_o
);
  import fqrr_pkg::*;

  localparam int unsigned IW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW  = IW + 1;
  localparam int unsigned QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned MemDepth = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned AW  = $clog2(MemDepth);

  // Per-queue pointers and the round-robin start
  logic [IW-1:0] head_q  [NUM_QUEUES];
  logic [IW-1:0] head_d  [NUM_QUEUES];
  logic [CW-1:0] count_q [NUM_QUEUES];
  logic [CW-1:0] count_d [NUM_QUEUES];
  logic [QW-1:0] next_start_q, next_start_d;

  // Ring memory and its registered read data
  logic [IdW-1:0] ring_mem_q [MemDepth];
  logic [IdW-1:0] rd_data_q;

  // Result stage
  logic            res_valid_q;
  status_e         res_status_q, res_status_d;
  logic [SelW-1:0] res_queue_q, res_queue_d;
  logic            res_last_q, res_last_d;

  logic            xfer;
  logic            is_pop;
  logic            sel_ok;
  logic [QW-1:0]   sel;
  logic            enq_full;
  logic            hit;
  logic [QW-1:0]   found;
  logic [QW:0]     scan_idx;
  logic            any_left;
  logic [IW-1:0]   pos_q_head;
  logic [PW-1:0]   tail_sum;
  logic [IW-1:0]   tail_pos;
  logic [QW-1:0]   mem_queue;
  logic [IW-1:0]   mem_pos;
  logic [AW-1:0]   mem_addr;
  logic            mem_wr;
  logic            mem_rd;

  assign xfer   = in_i.valid && in_i.ready;
  assign is_pop = (in_i.func == FN_POP);
  assign in_i.ready = !res_valid_q || out_o.ready;

  // Decode the enqueue target; a selector past the last queue counts as full
  assign sel_ok   = {1'b0, in_i.queue_sel} < (SelW + 1)'(NUM_QUEUES);
  assign sel      = QW'(in_i.queue_sel);
  assign enq_full = !sel_ok || (count_q[sel] == CW'(QUEUE_DEPTH));

  // Find the first non-empty queue, starting at the round-robin pointer
  always_comb begin
    hit      = 1'b0;
    found    = '0;
    scan_idx = '0;
    for (int k = 0; k < NUM_QUEUES; k++) begin
      scan_idx = {1'b0, next_start_q} + (QW + 1)'(k);
      if (scan_idx >= (QW + 1)'(NUM_QUEUES)) begin
        scan_idx = scan_idx - (QW + 1)'(NUM_QUEUES);
      end
      if (!hit && count_q[scan_idx[QW-1:0]] != '0) begin
        hit   = 1'b1;
        found = scan_idx[QW-1:0];
      end
    end
  end

  // Check whether anything remains once the found queue gives up its head
  always_comb begin
    any_left = 1'b0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (QW'(i) == found) begin
        if (count_q[i] > CW'(1)) any_left = 1'b1;
      end else if (count_q[i] != '0) begin
        any_left = 1'b1;
      end
    end
  end

  // Tail slot of the enqueue target, wrapped once around the ring
  assign pos_q_head = head_q[sel];
  assign tail_sum   = {1'b0, pos_q_head} + PW'(count_q[sel]);
  assign tail_pos   = (tail_sum >= PW'(QUEUE_DEPTH)) ?
                      IW'(tail_sum - PW'(QUEUE_DEPTH)) : tail_sum[IW-1:0];

  assign mem_queue = is_pop ? found : sel;
  assign mem_pos   = is_pop ? head_q[found] : tail_pos;
  assign mem_addr  = AW'(mem_queue) * AW'(QUEUE_DEPTH) + AW'(mem_pos);
  assign mem_wr    = xfer && !is_pop && !enq_full;
  assign mem_rd    = xfer && is_pop && hit;

  // Update pointers and form the result fields
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    next_start_d = next_start_q;
    res_status_d = ST_ENQ;
    res_queue_d  = '0;
    res_last_d   = 1'b0;
    if (!is_pop) begin
      res_queue_d = in_i.queue_sel;
      if (enq_full) begin
        res_status_d = ST_FULL;
      end else begin
        res_status_d = ST_ENQ;
        count_d[sel] = count_q[sel] + CW'(1);
      end
    end else if (!hit) begin
      res_status_d = ST_EMPTY;
    end else begin
      res_status_d   = ST_POP;
      res_queue_d    = SelW'(found);
      res_last_d     = !any_left;
      count_d[found] = count_q[found] - CW'(1);
      head_d[found]  = (head_q[found] == IW'(QUEUE_DEPTH - 1)) ?
                       '0 : head_q[found] + IW'(1);
      next_start_d   = (found == QW'(NUM_QUEUES - 1)) ? '0 : found + QW'(1);
    end
  end

  // Hold control state; advance on each transfer, clear result valid when the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      next_start_q <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (xfer) begin
        head_q       <= head_d;
        count_q      <= count_d;
        next_start_q <= next_start_d;
      end
      if (xfer) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Capture result fields on transfer
  always_ff @(posedge clk_i) begin
    if (xfer) begin
      res_status_q <= res_status_d;
      res_queue_q  <= res_queue_d;
      res_last_q   <= res_last_d;
    end
  end

  // Ring memory: at most one write or one registered read per transfer
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      ring_mem_q[mem_addr] <= in_i.flight_id;
    end
    if (mem_rd) begin
      rd_data_q <= ring_mem_q[mem_addr];
    end
  end

  assign out_o.valid     = res_valid_q;
  assign out_o.status    = res_status_q;
  assign out_o.out_id    = (res_status_q == ST_POP) ? rd_data_q : '0;
  assign out_o.out_queue = res_queue_q;
  assign out_o.last      = res_last_q;

  // A pop that finds every queue empty reports nothing to pop
  logic all_empty;
  always_comb begin
    all_empty = 1'b1;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (count_q[i] != '0) all_empty = 1'b0;
    end
  end

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && is_pop && all_empty) |=> (out_o.status == ST_EMPTY))
    else $error("pop on empty queues did not report empty");

  a_last_only_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (out_o.status == ST_POP))
    else $error("last flag set on a result that is not a pop");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && is_pop && hit && !any_left) |=> all_empty)
    else $error("final pop left entries behind");

  a_enq_ok_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !is_pop && !enq_full) |=> !all_empty)
    else $error("accepted enqueue left all queues empty");

endmodule

// File: dv/tb_four_queue_round_robin_merge_unit.sv
// Testbench for four_queue_round_robin_merge_unit: a directed table, then random
// bursts of fills, drains and mixed traffic, checked against a ring predictor or typed rows.
// Depends on fqrr_pkg, fqrr_in_if, fqrr_out_if and the unit itself.
`timescale 1ns / 1ps

module tb_four_queue_round_robin_merge_unit;
  import fqrr_pkg::*;

  localparam int unsigned QDEPTH     = 64;
  localparam int unsigned NQ         = 4;
  localparam int unsigned ITEM_GOAL  = 1200;
  localparam int unsigned STUCK_MAX  = 400;
  localparam logic [IdW-1:0] ID_ONES = {IdW{1'b1}};

  typedef struct packed {
    status_e          st;
    logic [IdW-1:0]   id;
    logic [SelW-1:0]  src;
    logic             last;
  } merge_res_t;

  typedef struct packed {
    func_e            fn;
    logic [SelW-1:0]  sel;
    logic [IdW-1:0]   id;
    logic             typed;
    merge_res_t       want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fqrr_in_if  in_if ();
  fqrr_out_if out_if ();

  four_queue_round_robin_merge_unit #(
    .QUEUE_DEPTH (QDEPTH),
    .NUM_QUEUES  (NQ)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state: one ring per queue plus the round-robin start
  logic [IdW-1:0] ring_mem [NQ][QDEPTH];
  int unsigned    ring_head [NQ] = '{default: 0};
  int unsigned    ring_cnt  [NQ] = '{default: 0};
  int unsigned    rr_start = 0;

  merge_res_t pending_results [$];
  merge_res_t row_expect;
  logic       row_typed = 1'b0;
  bit         calm = 1'b0;
  int         mismatch_count = 0;
  int         stuck_cycles = 0;
  int         items_sent = 0;
  merge_res_t seen_exp;
  merge_res_t seen_pred;
  bit         moved;

  // Directed table: empty pops, all-zero and all-ones ids, bit patterns, round-robin order
  stim_row_t dir_rows [22] = '{
    '{FN_POP, 2'd0, 40'd0,          1'b1, '{ST_EMPTY, 40'd0, 2'd0, 1'b0}},
    '{FN_POP, 2'd3, ID_ONES,        1'b1, '{ST_EMPTY, 40'd0, 2'd0, 1'b0}},
    '{FN_ENQ, 2'd0, 40'd0,          1'b1, '{ST_ENQ,   40'd0, 2'd0, 1'b0}},
    '{FN_ENQ, 2'd1, ID_ONES,        1'b1, '{ST_ENQ,   40'd0, 2'd1, 1'b0}},
    '{FN_ENQ, 2'd2, 40'h4142434445, 1'b1, '{ST_ENQ,   40'd0, 2'd2, 1'b0}},
    '{FN_ENQ, 2'd3, 40'h5555555555, 1'b1, '{ST_ENQ,   40'd0, 2'd3, 1'b0}},
    '{FN_ENQ, 2'd3, 40'hAAAAAAAAAA, 1'b1, '{ST_ENQ,   40'd0, 2'd3, 1'b0}},
    '{FN_ENQ, 2'd0, 40'h0000000001, 1'b1, '{ST_ENQ,   40'd0, 2'd0, 1'b0}},
    '{FN_POP, 2'd3, ID_ONES,        1'b0, '0},
    '{FN_POP, 2'd0, 40'd0,          1'b0, '0},
    '{FN_POP, 2'd1, 40'h8000000000, 1'b0, '0},
    '{FN_POP, 2'd2, 40'd0,          1'b0, '0},
    '{FN_POP, 2'd0, 40'd0,          1'b0, '0},
    '{FN_POP, 2'd0, 40'd0,          1'b0, '0},
    '{FN_POP, 2'd0, 40'd0,          1'b1, '{ST_EMPTY, 40'd0, 2'd0, 1'b0}},
    '{FN_ENQ, 2'd1, 40'h8000000001, 1'b1, '{ST_ENQ,   40'd0, 2'd1, 1'b0}},
    '{FN_ENQ, 2'd2, 40'h7FFFFFFFFE, 1'b1, '{ST_ENQ,   40'd0, 2'd2, 1'b0}},
    '{FN_POP, 2'd0, 40'd0,          1'b0, '0},
    '{FN_ENQ, 2'd0, 40'h123456789A, 1'b1, '{ST_ENQ,   40'd0, 2'd0, 1'b0}},
    '{FN_POP, 2'd0, 40'd0,          1'b0, '0},
    '{FN_POP, 2'd0, 40'd0,          1'b0, '0},
    '{FN_POP, 2'd1, 40'd0,          1'b1, '{ST_EMPTY, 40'd0, 2'd0, 1'b0}}
  };

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned queued_total();
    int unsigned sum;
    sum = 0;
    for (int k = 0; k < NQ; k++) sum += ring_cnt[k];
    return sum;
  endfunction

  // Advance the predictor by one transfer and return the result it causes
  function automatic merge_res_t merge_predict(func_e fn, logic [SelW-1:0] sel,
                                               logic [IdW-1:0] id);
    merge_res_t  r;
    int unsigned found;
    int unsigned q;
    r = '{ST_ENQ, '0, '0, 1'b0};
    if (fn == FN_ENQ) begin
      r.src = sel;
      if (sel >= NQ || ring_cnt[sel] >= QDEPTH) begin
        r.st = ST_FULL;
      end else begin
        ring_mem[sel][(ring_head[sel] + ring_cnt[sel]) % QDEPTH] = id;
        ring_cnt[sel]++;
      end
    end else begin
      found = NQ;
      for (int k = 0; k < NQ; k++) begin
        q = (rr_start + k) % NQ;
        if (found == NQ && ring_cnt[q] != 0) found = q;
      end
      if (found == NQ) begin
        r.st = ST_EMPTY;
      end else begin
        r.st  = ST_POP;
        r.id  = ring_mem[found][ring_head[found]];
        r.src = found[SelW-1:0];
        ring_head[found] = (ring_head[found] + 1) % QDEPTH;
        ring_cnt[found]--;
        rr_start = (found + 1) % NQ;
        r.last = (queued_total() == 0);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [IdW-1:0] rand_id();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ID_ONES;
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Hold one item on the input until it transfers; return at the next falling edge
  task automatic drive_item(func_e fn, logic [SelW-1:0] sel, logic [IdW-1:0] id);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.func      = fn;
    in_if.queue_sel = sel;
    in_if.flight_id = id;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Result sink: draw a stall for every result
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
    end
  end

  // Compare results, predict on input transfers, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_if.status), 64'd0);
        end else begin
          seen_exp = pending_results.pop_front();
          if (out_if.status !== seen_exp.st)
            report_mismatch("status", 64'(out_if.status), 64'(seen_exp.st));
          if (out_if.out_id !== seen_exp.id)
            report_mismatch("out_id", 64'(out_if.out_id), 64'(seen_exp.id));
          if (out_if.out_queue !== seen_exp.src)
            report_mismatch("out_queue", 64'(out_if.out_queue), 64'(seen_exp.src));
          if (out_if.last !== seen_exp.last)
            report_mismatch("last", 64'(out_if.last), 64'(seen_exp.last));
        end
      end
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        moved = 1'b1;
        seen_pred = merge_predict(func_e'(in_if.func), in_if.queue_sel, in_if.flight_id);
        pending_results.push_back(row_typed ? row_expect : seen_pred);
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_MAX) begin
        $display("tb_four_queue_round_robin_merge_unit: errors");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned mode;
    int unsigned q;
    int unsigned n;
    in_if.valid     = 1'b0;
    in_if.func      = FN_ENQ;
    in_if.queue_sel = '0;
    in_if.flight_id = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      row_typed  = dir_rows[i].typed;
      row_expect = dir_rows[i].want;
      drive_item(dir_rows[i].fn, dir_rows[i].sel, dir_rows[i].id);
    end
    row_typed = 1'b0;

    // Random bursts: fill one queue past full, drain everything, or mix
    while (items_sent < ITEM_GOAL) begin
      mode = $urandom_range(0, 9);
      calm = ($urandom_range(0, 3) == 0);
      if (mode == 0) begin
        q = $urandom_range(0, NQ - 1);
        n = QDEPTH - ring_cnt[q] + $urandom_range(1, 4);
        repeat (n) drive_item(FN_ENQ, q[SelW-1:0], rand_id());
      end else if (mode <= 2) begin
        while (queued_total() != 0)
          drive_item(FN_POP, SelW'($urandom), rand_id());
        repeat ($urandom_range(1, 3)) drive_item(FN_POP, SelW'($urandom), rand_id());
      end else begin
        repeat ($urandom_range(8, 24)) begin
          if ($urandom_range(0, 9) < 4)
            drive_item(FN_POP, SelW'($urandom), rand_id());
          else
            drive_item(FN_ENQ, SelW'($urandom), rand_id());
        end
      end
    end
    in_if.valid = 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("tb_four_queue_round_robin_merge_unit: clean");
    else
      $display("tb_four_queue_round_robin_merge_unit: errors");
    $finish;
  end

endmodule

// File: files.f
rtl/fqrr_pkg.sv
rtl/fqrr_in_if.sv
rtl/fqrr_out_if.sv
rtl/four_queue_round_robin_merge_unit.sv
dv/tb_four_queue_round_robin_merge_unit.sv
